// ===== rtl/cle_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cle_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int VAL_W    = 32;
  localparam int POS_W    = 16;
  localparam int ACT_W    = 3;
  localparam int STAT_W   = 2;
  localparam int LEN_W    = 5;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 40;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_APPEND     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_READ       = 3'd2;
  localparam logic [ACT_W-1:0] ACT_REMOVE_ONE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_REMOVE_ALL = 3'd4;
  localparam logic [ACT_W-1:0] ACT_CLEAR      = 3'd5;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  // Command kinds broadcast to the cell row.
  localparam logic [1:0] CMD_NONE   = 2'd0;
  localparam logic [1:0] CMD_LOAD   = 2'd1;
  localparam logic [1:0] CMD_INSERT = 2'd2;
  localparam logic [1:0] CMD_DELETE = 2'd3;

  typedef struct packed {
    logic [1:0]              kind;
    logic [IDX_W-1:0]        at;
    logic [CNT_W-1:0]        count;
    logic signed [VAL_W-1:0] value;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/cle_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cle_cell (
  input  wire logic                            clk,
  input  wire logic [cle_pkg::IDX_W-1:0]       cell_idx,
  input  wire cle_pkg::cell_cmd_t              cmd,
  input  wire logic signed [cle_pkg::VAL_W-1:0] left_data,
  input  wire logic signed [cle_pkg::VAL_W-1:0] right_data,
  output logic signed [cle_pkg::VAL_W-1:0]     data,
  output logic                                 match
);

  logic signed [cle_pkg::VAL_W-1:0] data_r;
  logic signed [cle_pkg::VAL_W-1:0] data_nxt;
  logic [cle_pkg::CNT_W-1:0]        my_pos;

  assign my_pos = cle_pkg::CNT_W'(cell_idx);

  always_comb begin
    data_nxt = data_r;
    case (cmd.kind)
      cle_pkg::CMD_LOAD: begin
        if (cell_idx == cmd.at) data_nxt = cmd.value;
      end
      cle_pkg::CMD_INSERT: begin
        // Cells above the insert point move up by one place.
        if (cell_idx == cmd.at) begin
          data_nxt = cmd.value;
        end else if (cell_idx > cmd.at && my_pos <= cmd.count) begin
          data_nxt = left_data;
        end
      end
      cle_pkg::CMD_DELETE: begin
        // Cells from the removed place on close the gap from above.
        if (cell_idx >= cmd.at && (my_pos + cle_pkg::CNT_W'(1)) < cmd.count) begin
          data_nxt = right_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data  = data_r;
  assign match = (data_r == cmd.value);

endmodule

`default_nettype wire

// ===== rtl/cle_wrap.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cle_wrap (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic signed [cle_pkg::POS_W-1:0] pos,
  input  wire logic [cle_pkg::CNT_W-1:0]        len,
  output logic                                  done,
  output logic [cle_pkg::IDX_W-1:0]             idx
);

  localparam int STEP_W = $clog2(cle_pkg::POS_W);

  logic                             busy_r, busy_nxt;
  logic                             done_r, done_nxt;
  logic [STEP_W-1:0]                step_r, step_nxt;
  logic [cle_pkg::POS_W-1:0]        mag_r, mag_nxt;
  logic [cle_pkg::CNT_W-1:0]        rem_r, rem_nxt;
  logic [cle_pkg::CNT_W-1:0]        len_r, len_nxt;
  logic                             neg_r, neg_nxt;
  logic [cle_pkg::CNT_W:0]          shifted;
  logic [cle_pkg::CNT_W-1:0]        wrapped;

  // One quotient bit per cycle, restoring remainder on the magnitude.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    len_nxt  = len_r;
    neg_nxt  = neg_r;
    shifted  = {rem_r, mag_r[cle_pkg::POS_W-1]};
    if (shifted >= {1'b0, len_r}) shifted = shifted - {1'b0, len_r};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      neg_nxt  = pos[cle_pkg::POS_W-1];
      mag_nxt  = pos[cle_pkg::POS_W-1] ? cle_pkg::POS_W'(-pos) : cle_pkg::POS_W'(pos);
      rem_nxt  = '0;
      len_nxt  = len;
    end else if (busy_r) begin
      rem_nxt  = shifted[cle_pkg::CNT_W-1:0];
      mag_nxt  = {mag_r[cle_pkg::POS_W-2:0], 1'b0};
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(cle_pkg::POS_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    len_r <= len_nxt;
    neg_r <= neg_nxt;
  end

  // A negative position with a nonzero remainder counts back from the end.
  assign wrapped = (neg_r && rem_r != '0) ? (len_r - rem_r) : rem_r;
  assign idx     = wrapped[cle_pkg::IDX_W-1:0];
  assign done    = done_r;

endmodule

`default_nettype wire

// ===== rtl/circular_list_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Ports                  Contents
// in_       request    tvalid/tready/tdata    action, item_value, position
// out_      result     tvalid/tready/tdata    status, read_value, list_length
//
// One request at a time. Append, clear and unknown actions go straight to the
// output register; insert and read, unless refused, first pass the 16-step
// remainder unit; remove scans the list, one cell per scan cycle.
// Reset is synchronous and active low and empties the list; the cell row
// itself is not cleared. A request may be taken while a result still waits
// on out_; a new result waits in a holding register until out_ frees.

module circular_list_engine (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [2:0] action, [34:3] item_value, [50:35] position, [55:51] zero
  input  wire logic [cle_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [1:0] status, [33:2] read_value, [38:34] list_length, [39] zero
  output logic [cle_pkg::OUT_DATA_W-1:0]         out_tdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WRAP = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_PUSH = 2'd3;

  localparam int CAP = cle_pkg::CAPACITY;
  localparam int IW  = cle_pkg::IDX_W;
  localparam int CW  = cle_pkg::CNT_W;
  localparam int VW  = cle_pkg::VAL_W;

  logic [1:0]                      state_r, state_nxt;
  logic [CW-1:0]                   count_r, count_nxt;
  logic [CW-1:0]                   k_r, k_nxt;
  logic                            found_r, found_nxt;
  logic [cle_pkg::ACT_W-1:0]       act_r, act_nxt;
  logic signed [VW-1:0]            val_r, val_nxt;
  logic [cle_pkg::STAT_W-1:0]      res_status_r, res_status_nxt;
  logic signed [VW-1:0]            res_read_r, res_read_nxt;
  logic                            out_tvalid_r;
  logic [cle_pkg::OUT_DATA_W-1:0]  out_tdata_r;

  logic [cle_pkg::ACT_W-1:0]       in_act;
  logic signed [VW-1:0]            in_val;
  logic signed [cle_pkg::POS_W-1:0] in_pos;
  logic                            accept;
  logic                            slot_free;
  logic                            wrap_start;
  logic                            wrap_done;
  logic [IW-1:0]                   wrap_idx;
  logic                            full;

  cle_pkg::cell_cmd_t              cmd;
  logic signed [VW-1:0]            cell_data [CAP];
  logic [CAP-1:0]                  cell_match;

  assign in_act    = in_tdata[2:0];
  assign in_val    = in_tdata[34:3];
  assign in_pos    = in_tdata[50:35];
  // No request is taken while reset is held.
  assign in_tready = rst_n && (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign slot_free = !out_tvalid_r || out_tready;
  assign full      = (count_r >= CW'(CAP));

  cle_wrap u_wrap (
    .clk   (clk),
    .rst_n (rst_n),
    .start (wrap_start),
    .pos   (in_pos),
    .len   (count_r),
    .done  (wrap_done),
    .idx   (wrap_idx)
  );

  for (genvar g = 0; g < CAP; g++) begin : g_cell
    logic signed [VW-1:0] left_d;
    logic signed [VW-1:0] right_d;
    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_left
      assign left_d = cell_data[g-1];
    end
    if (g == CAP - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_right
      assign right_d = cell_data[g+1];
    end
    cle_cell u_cell (
      .clk        (clk),
      .cell_idx   (IW'(g)),
      .cmd        (cmd),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[g]),
      .match      (cell_match[g])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    k_nxt          = k_r;
    found_nxt      = found_r;
    act_nxt        = act_r;
    val_nxt        = val_r;
    res_status_nxt = res_status_r;
    res_read_nxt   = res_read_r;
    wrap_start     = 1'b0;
    cmd.kind       = cle_pkg::CMD_NONE;
    cmd.at         = '0;
    cmd.count      = count_r;
    cmd.value      = val_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          act_nxt        = in_act;
          val_nxt        = in_val;
          res_status_nxt = cle_pkg::ST_OK;
          res_read_nxt   = '0;
          k_nxt          = '0;
          found_nxt      = 1'b0;
          state_nxt      = S_PUSH;
          case (in_act)
            cle_pkg::ACT_APPEND: begin
              if (full) begin
                res_status_nxt = cle_pkg::ST_FULL;
              end else begin
                cmd.kind  = cle_pkg::CMD_LOAD;
                cmd.at    = count_r[IW-1:0];
                cmd.value = in_val;
                count_nxt = count_r + CW'(1);
              end
            end
            cle_pkg::ACT_INSERT: begin
              if (count_r == '0) begin
                res_status_nxt = cle_pkg::ST_EMPTY;
              end else if (full) begin
                res_status_nxt = cle_pkg::ST_FULL;
              end else begin
                wrap_start = 1'b1;
                state_nxt  = S_WRAP;
              end
            end
            cle_pkg::ACT_READ: begin
              if (count_r == '0) begin
                res_status_nxt = cle_pkg::ST_EMPTY;
              end else begin
                wrap_start = 1'b1;
                state_nxt  = S_WRAP;
              end
            end
            cle_pkg::ACT_REMOVE_ONE, cle_pkg::ACT_REMOVE_ALL: begin
              state_nxt = S_SCAN;
            end
            cle_pkg::ACT_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_WRAP: begin
        if (wrap_done) begin
          state_nxt = S_PUSH;
          if (act_r == cle_pkg::ACT_INSERT) begin
            cmd.kind  = cle_pkg::CMD_INSERT;
            cmd.at    = wrap_idx;
            count_nxt = count_r + CW'(1);
          end else begin
            res_read_nxt = cell_data[wrap_idx];
          end
        end
      end
      S_SCAN: begin
        // One cell is examined per cycle; for remove-all, after a removal the same
        // place is examined again, since the next element has moved into it.
        if (k_r >= count_r) begin
          res_status_nxt = found_r ? cle_pkg::ST_OK : cle_pkg::ST_NOTFOUND;
          state_nxt      = S_PUSH;
        end else if (cell_match[k_r[IW-1:0]]) begin
          cmd.kind  = cle_pkg::CMD_DELETE;
          cmd.at    = k_r[IW-1:0];
          count_nxt = count_r - CW'(1);
          found_nxt = 1'b1;
          if (act_r == cle_pkg::ACT_REMOVE_ONE) begin
            res_status_nxt = cle_pkg::ST_OK;
            state_nxt      = S_PUSH;
          end
        end else begin
          k_nxt = k_r + CW'(1);
        end
      end
      S_PUSH: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (state_r == S_PUSH && slot_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
    k_r          <= k_nxt;
    found_r      <= found_nxt;
    act_r        <= act_nxt;
    val_r        <= val_nxt;
    res_status_r <= res_status_nxt;
    res_read_r   <= res_read_nxt;
    if (state_r == S_PUSH && slot_free) begin
      out_tdata_r <= {1'b0, cle_pkg::LEN_W'(count_r), res_read_r, res_status_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAP))
    else $error("list length above capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_act == cle_pkg::ACT_CLEAR) |=> (count_r == '0))
    else $error("clear did not empty the list");

  a_scan_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |=> (count_r <= $past(count_r)))
    else $error("list grew during a removal scan");

  a_push_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH && slot_free) |=> out_tvalid)
    else $error("finished result not presented");

endmodule

`default_nettype wire

// ===== dv/tb_circular_list_engine.sv =====
`timescale 1ns / 1ps

module tb_circular_list_engine;

  localparam int RANDOM_ITEMS = 1300;
  localparam int CALM_TAIL    = 150;
  localparam int CYCLE_LIMIT  = 400000;

  // Codes outside the defined action set; the block must leave the list as it is and answer OK.
  localparam logic [cle_pkg::ACT_W-1:0] ACT_UNUSED_6 = 3'd6;
  localparam logic [cle_pkg::ACT_W-1:0] ACT_UNUSED_7 = 3'd7;

  typedef struct {
    logic [cle_pkg::STAT_W-1:0] status;
    logic [cle_pkg::VAL_W-1:0]  read_value;
    logic [cle_pkg::LEN_W-1:0]  list_length;
  } list_result_t;

  // Mirrors the list contents and holds the results still owed by the block.
  class list_scoreboard;
    logic [cle_pkg::VAL_W-1:0] cells[cle_pkg::CAPACITY];
    int unsigned               count;
    list_result_t              awaited[$];
    int unsigned               errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    function int unsigned wrap(logic [cle_pkg::POS_W-1:0] pos);
      int p;
      int r;
      p = int'($signed(pos));
      r = p % int'(count);
      if (r < 0) begin
        r += int'(count);
      end
      return r;
    endfunction

    function void drop_at(int unsigned idx);
      int unsigned k;
      for (k = idx; k + 1 < count; k++) begin
        cells[k] = cells[k + 1];
      end
      count--;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function void note_request(logic [cle_pkg::ACT_W-1:0] act,
                               logic [cle_pkg::VAL_W-1:0] val,
                               logic [cle_pkg::POS_W-1:0] pos);
      list_result_t res;
      int unsigned  idx;
      int unsigned  k;
      bit           found;
      res.status     = cle_pkg::ST_OK;
      res.read_value = '0;
      found          = 1'b0;
      case (act)
        cle_pkg::ACT_APPEND: begin
          if (count >= cle_pkg::CAPACITY) begin
            res.status = cle_pkg::ST_FULL;
          end else begin
            cells[count] = val;
            count++;
          end
        end
        cle_pkg::ACT_INSERT: begin
          if (count == 0) begin
            res.status = cle_pkg::ST_EMPTY;
          end else if (count >= cle_pkg::CAPACITY) begin
            res.status = cle_pkg::ST_FULL;
          end else begin
            idx = wrap(pos);
            for (k = count; k > idx; k--) begin
              cells[k] = cells[k - 1];
            end
            cells[idx] = val;
            count++;
          end
        end
        cle_pkg::ACT_READ: begin
          if (count == 0) begin
            res.status = cle_pkg::ST_EMPTY;
          end else begin
            res.read_value = cells[wrap(pos)];
          end
        end
        cle_pkg::ACT_REMOVE_ONE: begin
          for (k = 0; k < count && !found; k++) begin
            if (cells[k] == val) begin
              drop_at(k);
              found = 1'b1;
            end
          end
          res.status = found ? cle_pkg::ST_OK : cle_pkg::ST_NOTFOUND;
        end
        cle_pkg::ACT_REMOVE_ALL: begin
          k = 0;
          while (k < count) begin
            if (cells[k] == val) begin
              drop_at(k);
              found = 1'b1;
            end else begin
              k++;
            end
          end
          res.status = found ? cle_pkg::ST_OK : cle_pkg::ST_NOTFOUND;
        end
        cle_pkg::ACT_CLEAR: begin
          count = 0;
        end
        default: begin
        end
      endcase
      res.list_length = cle_pkg::LEN_W'(count);
      awaited.push_back(res);
    endfunction

    function void check_result(logic [cle_pkg::OUT_DATA_W-1:0] data);
      list_result_t               want;
      logic [cle_pkg::STAT_W-1:0] got_status;
      logic [cle_pkg::VAL_W-1:0]  got_value;
      logic [cle_pkg::LEN_W-1:0]  got_length;
      got_status = data[1:0];
      got_value  = data[33:2];
      got_length = data[38:34];
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d value %h length %0d",
                 $time, got_status, got_value, got_length);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got_status !== want.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, want.status, got_status);
        errors++;
      end
      if (got_value !== want.read_value) begin
        $display("%0t: read_value mismatch: expected %h, actual %h",
                 $time, want.read_value, got_value);
        errors++;
      end
      if (got_length !== want.list_length) begin
        $display("%0t: list_length mismatch: expected %0d, actual %0d",
                 $time, want.list_length, got_length);
        errors++;
      end
    endfunction
  endclass

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [cle_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [cle_pkg::OUT_DATA_W-1:0] out_tdata;

  list_scoreboard sb;
  bit             idle_on    = 1'b1;
  int             stall_left = 0;
  int             cycles     = 0;

  circular_list_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: check each result taken; short random stall bursts if idle_on.
  always @(posedge clk) begin
    if (out_tvalid === 1'b1 && out_tready) begin
      sb.check_result(out_tdata);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 7) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Drives one request on in_ and returns as soon as the block has taken it.
  task automatic send_request(input logic [cle_pkg::ACT_W-1:0] act,
                              input logic [cle_pkg::VAL_W-1:0] val,
                              input logic [cle_pkg::POS_W-1:0] pos);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, pos, val, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(act, val, pos);
  endtask

  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [cle_pkg::ACT_W-1:0] pick_action(int mode);
    int weights[3][7] = '{'{45, 30, 15, 5, 2, 1, 2},
                          '{10, 10, 20, 28, 20, 7, 5},
                          '{22, 20, 25, 14, 10, 5, 4}};
    logic [cle_pkg::ACT_W-1:0] codes[6] = '{cle_pkg::ACT_APPEND, cle_pkg::ACT_INSERT,
                                            cle_pkg::ACT_READ, cle_pkg::ACT_REMOVE_ONE,
                                            cle_pkg::ACT_REMOVE_ALL, cle_pkg::ACT_CLEAR};
    int roll;
    int i;
    roll = $urandom_range(0, 99);
    for (i = 0; i < 6; i++) begin
      if (roll < weights[mode][i]) begin
        return codes[i];
      end
      roll -= weights[mode][i];
    end
    return $urandom_range(0, 1) ? ACT_UNUSED_6 : ACT_UNUSED_7;
  endfunction

  // A small pool of values makes repeats common, so removals find matches.
  function automatic logic [cle_pkg::VAL_W-1:0] pick_value();
    logic [cle_pkg::VAL_W-1:0] pool[6] = '{32'h0000_0000, 32'h0000_0001, 32'hffff_ffff,
                                           32'h7fff_ffff, 32'h8000_0000, 32'h0000_00a5};
    if ($urandom_range(0, 3) < 2) begin
      return pool[$urandom_range(0, 5)];
    end
    return $urandom;
  endfunction

  function automatic logic [cle_pkg::POS_W-1:0] pick_position();
    logic [cle_pkg::POS_W-1:0] edges[4] = '{16'h8000, 16'h7fff, 16'hffff, 16'h0000};
    case ($urandom_range(0, 3))
      0: return cle_pkg::POS_W'($urandom_range(0, 20));
      1: return -cle_pkg::POS_W'($urandom_range(1, 20));
      2: return cle_pkg::POS_W'($urandom);
      default: return edges[$urandom_range(0, 3)];
    endcase
  endfunction

  initial begin
    int                        n_real;
    int                        step;
    int                        mode;
    int                        i;
    bit                        drained;
    logic [cle_pkg::ACT_W-1:0] act;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Everything refused or trivial on an empty list.
    send_request(cle_pkg::ACT_READ, 32'h1234_5678, 16'h0000);
    send_request(cle_pkg::ACT_INSERT, 32'h0000_0001, 16'h0000);
    send_request(cle_pkg::ACT_REMOVE_ONE, 32'h0000_0000, 16'h0000);
    send_request(cle_pkg::ACT_REMOVE_ALL, 32'h0000_0000, 16'h0000);
    send_request(cle_pkg::ACT_CLEAR, 32'h0000_0000, 16'h0000);
    send_request(ACT_UNUSED_7, 32'hffff_ffff, 16'hffff);

    send_request(cle_pkg::ACT_APPEND, 32'h8000_0000, 16'h0000);
    send_request(cle_pkg::ACT_APPEND, 32'h7fff_ffff, 16'h0000);
    send_request(cle_pkg::ACT_INSERT, 32'h0000_0000, 16'h8000);
    send_request(cle_pkg::ACT_INSERT, 32'hffff_ffff, 16'h7fff);
    send_request(cle_pkg::ACT_READ, 32'h0000_0000, 16'hffff);
    send_request(cle_pkg::ACT_READ, 32'h0000_0000, 16'h8000);
    for (i = 0; i < cle_pkg::CAPACITY - 4; i++) begin
      send_request(cle_pkg::ACT_APPEND, i[0] ? 32'haaaa_aaaa : 32'h5555_5555, 16'h0000);
    end
    // Full list: both growing actions are refused.
    send_request(cle_pkg::ACT_APPEND, 32'h0000_0002, 16'h0000);
    send_request(cle_pkg::ACT_INSERT, 32'h0000_0002, 16'h0001);
    send_request(cle_pkg::ACT_READ, 32'h0000_0000, 16'h7fff);
    send_request(cle_pkg::ACT_REMOVE_ALL, 32'haaaa_aaaa, 16'h0000);
    send_request(cle_pkg::ACT_REMOVE_ONE, 32'h7fff_ffff, 16'h0000);
    send_request(cle_pkg::ACT_REMOVE_ONE, 32'h0000_3039, 16'h0000);
    send_request(ACT_UNUSED_6, 32'h0000_0000, 16'h0000);
    send_request(cle_pkg::ACT_CLEAR, 32'h0000_0000, 16'h0000);

    n_real  = 0;
    step    = 0;
    mode    = 0;
    drained = 1'b0;
    while (n_real < RANDOM_ITEMS) begin
      if (step % 64 == 0) begin
        mode = $urandom_range(0, 2);
      end
      if (!drained && n_real >= RANDOM_ITEMS / 2) begin
        wait_all_results();
        drained = 1'b1;
      end
      if (n_real >= RANDOM_ITEMS - CALM_TAIL) begin
        idle_on = 1'b0;
      end
      act = pick_action(mode);
      send_request(act, pick_value(), pick_position());
      if (act != ACT_UNUSED_6 && act != ACT_UNUSED_7) begin
        n_real++;
      end
      step++;
    end

    wait_all_results();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cle_pkg.sv
rtl/cle_cell.sv
rtl/cle_wrap.sv
rtl/circular_list_engine.sv
dv/tb_circular_list_engine.sv
